FILE: src/bba_pkg.sv
package bba_pkg;

  localparam int CNT_W  = 13;
  localparam int ADDR_W = 16;
  localparam int STAT_W = 2;

  localparam int NUM_SLOTS_DEF  = 16;
  localparam int REGION_DEF     = 4096;

  localparam logic [CNT_W-1:0] BUCKET_RESET = 13'd1024;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] rel;
  } slot_entry_t;

endpackage

FILE: src/bucket_bump_allocator.sv
// Channel   Ports                                              Handshake
// -------   -------------------------------------------------  ----------------------------
// request   in_kind, in_request_count, in_address_in           start & !busy
// result    out_address_out, out_status, out_slot_freed        out_valid, one-cycle strobe
// config    cfg_bucket_size                                    cfg_valid & cfg_ready
//
// Every request scans the slot table, one slot-table read per cycle through the shared slot
// compare while unread slots remain, then drains the read pipe and ends in the update/result
// state, after which out_valid strobes. busy stays high from start through the update state;
// the next start is taken while out_valid is up.
// rst_n is synchronous: clears all slot valid bits and sets bucket size to 1024.
// Results cannot be stalled; out_valid lasts exactly one cycle.
module bucket_bump_allocator #(
  parameter int NUM_SLOTS       = bba_pkg::NUM_SLOTS_DEF,
  parameter int REGION_ELEMENTS = bba_pkg::REGION_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_kind,
  input  logic [bba_pkg::CNT_W-1:0]   in_request_count,
  input  logic [bba_pkg::ADDR_W-1:0]  in_address_in,
  output logic                        out_valid,
  output logic [bba_pkg::ADDR_W-1:0]  out_address_out,
  output logic [bba_pkg::STAT_W-1:0]  out_status,
  output logic                        out_slot_freed,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bba_pkg::CNT_W-1:0]   cfg_bucket_size
);

  localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW     = $clog2(NUM_SLOTS + 1);
  localparam int BASE_W = $clog2(NUM_SLOTS * REGION_ELEMENTS + 1);
  localparam int SUM_W  = ((BASE_W > bba_pkg::ADDR_W) ? BASE_W : bba_pkg::ADDR_W) + 1;
  localparam int CNT_W  = bba_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]                     state_r;
  logic                           kind_r;
  logic [CNT_W-1:0]               req_n_r;
  logic [bba_pkg::ADDR_W-1:0]     addr_r;
  logic [CNT_W-1:0]               bucket_r;

  logic [CW-1:0]                  cnt_r;
  logic [BASE_W-1:0]              base_r;
  logic                           chk_vld_r;
  logic [SW-1:0]                  chk_idx_r;
  logic [BASE_W-1:0]              chk_base_r;
  bba_pkg::slot_entry_t           rd_data_r;

  logic                           sel_found_r;
  logic [SW-1:0]                  sel_idx_r;
  logic [BASE_W-1:0]              sel_base_r;
  bba_pkg::slot_entry_t           sel_ent_r;
  logic                           free_found_r;
  logic [SW-1:0]                  free_idx_r;
  logic [BASE_W-1:0]              free_base_r;

  logic [NUM_SLOTS-1:0]           slot_vld_r;
  bba_pkg::slot_entry_t           slot_mem [NUM_SLOTS];

  logic                           out_valid_r;
  logic [bba_pkg::ADDR_W-1:0]     out_addr_r;
  logic [bba_pkg::STAT_W-1:0]     out_status_r;
  logic                           out_freed_r;

  logic                           issue;
  logic                           chk_slot_vld;
  logic                           hit;

  // update-cycle results
  logic                           big;
  logic                           too_large;
  logic [CNT_W-1:0]               cap_ord;
  logic [CNT_W-1:0]               cap_new;
  logic [CNT_W:0]                 rel_sum;
  logic [CNT_W-1:0]               rel_sat;
  logic                           wr_en_nxt;
  logic [SW-1:0]                  wr_idx_nxt;
  bba_pkg::slot_entry_t           wr_ent_nxt;
  logic                           set_vld_nxt;
  logic                           clr_vld_nxt;
  logic [SUM_W-1:0]               grant_sum;
  logic [bba_pkg::ADDR_W-1:0]     grant_nxt;
  logic [bba_pkg::STAT_W-1:0]     status_nxt;
  logic                           freed_nxt;

  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_address_out = out_addr_r;
  assign out_status      = out_status_r;
  assign out_slot_freed  = out_freed_r;

  assign issue        = (state_r == ST_SCAN) && (cnt_r != CW'(NUM_SLOTS));
  assign chk_slot_vld = slot_vld_r[chk_idx_r];

  bba_slot_cmp #(
    .BASE_W (BASE_W)
  ) u_cmp (
    .kind     (kind_r),
    .slot_vld (chk_slot_vld),
    .req_n    (req_n_r),
    .addr     (addr_r),
    .base     (chk_base_r),
    .ent      (rd_data_r),
    .hit      (hit)
  );

  always_comb begin
    big       = req_n_r > bucket_r;
    too_large = 32'(req_n_r) > 32'(REGION_ELEMENTS);
    cap_ord   = (32'(bucket_r) > 32'(REGION_ELEMENTS)) ? CNT_W'(REGION_ELEMENTS) : bucket_r;
    cap_new   = big ? req_n_r : cap_ord;
    rel_sum   = {1'b0, sel_ent_r.rel} + {1'b0, req_n_r};
    rel_sat   = rel_sum[CNT_W] ? {CNT_W{1'b1}} : rel_sum[CNT_W-1:0];

    wr_en_nxt   = 1'b0;
    wr_idx_nxt  = sel_idx_r;
    wr_ent_nxt  = sel_ent_r;
    set_vld_nxt = 1'b0;
    clr_vld_nxt = 1'b0;
    grant_sum   = '0;
    status_nxt  = bba_pkg::ST_OK;
    freed_nxt   = 1'b0;

    if (kind_r == bba_pkg::KIND_ALLOC) begin
      if (too_large) begin
        status_nxt = bba_pkg::ST_TOO_LARGE;
      end else if (!big && sel_found_r) begin
        wr_en_nxt       = 1'b1;
        wr_ent_nxt.used = sel_ent_r.used + req_n_r;
        grant_sum       = SUM_W'(sel_base_r) + SUM_W'(sel_ent_r.used);
      end else if (free_found_r) begin
        wr_en_nxt   = 1'b1;
        set_vld_nxt = 1'b1;
        wr_idx_nxt  = free_idx_r;
        wr_ent_nxt  = '{cap: cap_new, used: req_n_r, rel: '0};
        grant_sum   = SUM_W'(free_base_r);
      end else begin
        status_nxt = bba_pkg::ST_NO_SLOT;
      end
    end else begin
      if (sel_found_r) begin
        wr_en_nxt      = 1'b1;
        wr_ent_nxt.rel = rel_sat;
        if (rel_sat == sel_ent_r.used) begin
          clr_vld_nxt = 1'b1;
          freed_nxt   = 1'b1;
        end
      end else begin
        status_nxt = bba_pkg::ST_NOT_FOUND;
      end
    end
    grant_nxt = grant_sum[bba_pkg::ADDR_W-1:0];
  end

  // slot table: one read per issuing scan cycle, one write in the update cycle
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= slot_mem[cnt_r[SW-1:0]];
    end
    if ((state_r == ST_UPD) && wr_en_nxt) begin
      slot_mem[wr_idx_nxt] <= wr_ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      bucket_r     <= bba_pkg::BUCKET_RESET;
      slot_vld_r   <= '0;
      chk_vld_r    <= 1'b0;
      sel_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_UPD);
      if (cfg_valid && cfg_ready) begin
        bucket_r <= cfg_bucket_size;
      end
      chk_vld_r <= issue;
      if (issue) begin
        chk_idx_r  <= cnt_r[SW-1:0];
        chk_base_r <= base_r;
        cnt_r      <= cnt_r + CW'(1);
        base_r     <= BASE_W'(base_r + BASE_W'(REGION_ELEMENTS));
      end
      if (chk_vld_r) begin
        if (hit && !sel_found_r) begin
          sel_found_r <= 1'b1;
          sel_idx_r   <= chk_idx_r;
          sel_base_r  <= chk_base_r;
          sel_ent_r   <= rd_data_r;
        end
        if (!chk_slot_vld && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= chk_idx_r;
          free_base_r  <= chk_base_r;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            kind_r       <= in_kind;
            req_n_r      <= in_request_count;
            addr_r       <= in_address_in;
            cnt_r        <= '0;
            base_r       <= '0;
            sel_found_r  <= 1'b0;
            free_found_r <= 1'b0;
            state_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // last slot is being checked this cycle
          if (cnt_r == CW'(NUM_SLOTS)) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (set_vld_nxt) begin
            slot_vld_r[wr_idx_nxt] <= 1'b1;
          end else if (clr_vld_nxt) begin
            slot_vld_r[wr_idx_nxt] <= 1'b0;
          end
          out_addr_r   <= grant_nxt;
          out_status_r <= status_nxt;
          out_freed_r  <= freed_nxt;
          state_r      <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in flight");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_freed_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_slot_freed) |-> (out_status == bba_pkg::ST_OK))
    else $error("slot freed on a failed request");

  a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != bba_pkg::ST_OK)) |-> (out_address_out == '0))
    else $error("nonzero address on an error status");
`endif

endmodule

FILE: src/bba_slot_cmp.sv
// Per-slot check shared by every step of the scan: fit test for an
// allocate, address range test for a release.
module bba_slot_cmp #(
  parameter int BASE_W = 17
) (
  input  logic                        kind,
  input  logic                        slot_vld,
  input  logic [bba_pkg::CNT_W-1:0]   req_n,
  input  logic [bba_pkg::ADDR_W-1:0]  addr,
  input  logic [BASE_W-1:0]           base,
  input  bba_pkg::slot_entry_t        ent,
  output logic                        hit
);

  localparam int CMP_W = ((BASE_W > bba_pkg::ADDR_W) ? BASE_W : bba_pkg::ADDR_W) + 1;

  logic [bba_pkg::CNT_W:0] fit_sum;
  logic [CMP_W-1:0]        lo;
  logic [CMP_W-1:0]        hi;
  logic [CMP_W-1:0]        a_ext;
  logic                    fits;
  logic                    in_range;

  assign fit_sum  = {1'b0, ent.used} + {1'b0, req_n};
  assign fits     = fit_sum <= {1'b0, ent.cap};
  assign lo       = CMP_W'(base);
  assign hi       = lo + CMP_W'(ent.used);
  assign a_ext    = CMP_W'(addr);
  // end of range is exclusive
  assign in_range = (a_ext >= lo) && (a_ext < hi);
  assign hit      = slot_vld && ((kind == bba_pkg::KIND_RELEASE) ? in_range : fits);

endmodule
